### sv/utf8s_pkg.sv
`timescale 1ns / 1ps
// Shared types and byte codes for the UTF-8 sanitizer.
// Used by utf8s_ctrl, utf8s_dp and utf8_sanitizer; depends on nothing.
package utf8s_pkg;

  // Control bytes that survive (tab, LF, CR) and the bounds of the kept ASCII range
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChDel = 8'd127;

  // Single-byte remaps from the 128..159 window
  localparam logic [7:0] ChEuroIn = 8'd128;
  localparam logic [7:0] ChNelIn  = 8'd133;
  localparam logic [7:0] Euro0 = 8'd226;
  localparam logic [7:0] Euro1 = 8'd130;
  localparam logic [7:0] Euro2 = 8'd172;

  // Latin-1 re-encoding
  localparam logic [7:0] Lat1Lo   = 8'd160;
  localparam logic [7:0] Lat1Hi   = 8'd192;
  localparam logic [7:0] LeadC2   = 8'd194;
  localparam logic [7:0] LeadC3   = 8'd195;
  localparam logic [7:0] Lat1Bias = 8'd64;

  // Lead byte ranges
  localparam logic [7:0] Lead3Min = 8'd224;
  localparam logic [7:0] Lead4Min = 8'd240;
  localparam logic [7:0] LeadEnd  = 8'd245;

  // Replacement character U+FFFD
  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;

  // Window: up to three held bytes plus the new one
  localparam int unsigned WinDepth = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // take the request byte into the window
    logic scan_step;  // latch decoded action, shift window
    logic emit_push;  // move one emit byte into the hold slot
    logic flush;      // send hold byte or end marker to the output
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // window empty
    logic act_stop;   // sequence incomplete, keep bytes for next request
    logic act_none;   // decoded action emits nothing
    logic emit_end;   // current emit byte is the final one of the action
    logic push_ok;    // hold slot can take a byte this cycle
    logic fin_needed; // something to send at the end of the request
    logic out_free;   // output register can be loaded this cycle
  } dp_stat_t;

endpackage

### sv/utf8_sanitizer.sv
`timescale 1ns / 1ps
// Per byte: the controller accepts it, takes one decode step per action and a final scan
// check, emits one byte per cycle while the hold slot can take it, and then finishes.
// Output backpressure can stall the emit and finish steps; no new byte is taken until finish.
// The last result is held back by one byte so it can carry out_last.
// Reset (rst, synchronous): empties the held partial sequence and the output.
// Top level of the UTF-8 sanitizer; instantiates utf8s_ctrl and utf8s_dp.
module utf8_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  utf8s_pkg::dp_cmd_t  cmd;
  utf8s_pkg::dp_stat_t stat;

  utf8s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  utf8s_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd       (cmd),
    .stat      (stat),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

### sv/utf8s_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the UTF-8 sanitizer: accept, scan, emit, finish.
// Depends on utf8s_pkg for state and command/status types.
module utf8s_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  utf8s_pkg::dp_stat_t stat,
  output utf8s_pkg::dp_cmd_t  cmd
);

  utf8s_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utf8s_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      utf8s_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = utf8s_pkg::ST_SCAN;
        end
      end
      utf8s_pkg::ST_SCAN: begin
        if (stat.scan_done || stat.act_stop) begin
          state_next = utf8s_pkg::ST_FIN;
        end else begin
          cmd.scan_step = 1'b1;
          if (!stat.act_none) state_next = utf8s_pkg::ST_EMIT;
        end
      end
      utf8s_pkg::ST_EMIT: begin
        if (stat.push_ok) begin
          cmd.emit_push = 1'b1;
          if (stat.emit_end) state_next = utf8s_pkg::ST_SCAN;
        end
      end
      utf8s_pkg::ST_FIN: begin
        if (!stat.fin_needed) begin
          state_next = utf8s_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = utf8s_pkg::ST_IDLE;
        end
      end
      default: state_next = utf8s_pkg::ST_IDLE;
    endcase
  end

endmodule

### sv/utf8s_dp.sv
`timescale 1ns / 1ps
// Datapath for the UTF-8 sanitizer: byte window, decoder, emit buffer,
// hold slot and output register. Depends on utf8s_pkg.
module utf8s_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  utf8s_pkg::dp_cmd_t  cmd,
  output utf8s_pkg::dp_stat_t stat,
  output logic [7:0]          out_byte,
  output logic                out_valid,
  output logic                out_last,
  output logic                res_valid,
  input  logic                res_stall
);

  // Window, always aligned so entry 0 is the next byte to examine
  logic [7:0] pend [utf8s_pkg::WinDepth];
  logic [2:0] fill;
  logic       is_last;

  // Bytes of the current action
  logic [7:0] emit_bytes [utf8s_pkg::WinDepth];
  logic [2:0] emit_cnt;
  logic [1:0] emit_idx;

  // One-byte hold so the final byte of a request can carry out_last
  logic [7:0] hold;
  logic       hold_valid;

  // Decoder outputs
  logic [7:0] act_bytes [utf8s_pkg::WinDepth];
  logic [2:0] act_cnt;
  logic [2:0] act_adv;
  logic       act_stop;

  logic [7:0] c;
  logic [1:0] need;
  logic       seq_wait, seq_bad, seq_hit;
  logic       out_free, out_load;
  logic [7:0] out_byte_next;
  logic       out_valid_next, out_last_next;

  // Decode the action at the head of the window
  always_comb begin
    c         = pend[0];
    need      = 2'd0;
    seq_wait  = 1'b0;
    seq_bad   = 1'b0;
    seq_hit   = 1'b0;
    act_cnt   = 3'd0;
    act_adv   = 3'd1;
    act_stop  = 1'b0;
    for (int k = 0; k < utf8s_pkg::WinDepth; k++) act_bytes[k] = pend[k];

    if (c < utf8s_pkg::LeadC2 || c >= utf8s_pkg::LeadEnd) begin
      // Lone byte: remap, drop or replace
      if (c >= utf8s_pkg::LeadEnd) begin
        act_bytes[0] = utf8s_pkg::Repl0;
        act_bytes[1] = utf8s_pkg::Repl1;
        act_bytes[2] = utf8s_pkg::Repl2;
        act_cnt      = 3'd3;
      end else if (c < utf8s_pkg::ChSpace) begin
        if (c == utf8s_pkg::ChTab || c == utf8s_pkg::ChLf || c == utf8s_pkg::ChCr)
          act_cnt = 3'd1;
      end else if (c < utf8s_pkg::ChDel) begin
        act_cnt = 3'd1;
      end else if (c < utf8s_pkg::Lat1Lo) begin
        if (c == utf8s_pkg::ChEuroIn) begin
          act_bytes[0] = utf8s_pkg::Euro0;
          act_bytes[1] = utf8s_pkg::Euro1;
          act_bytes[2] = utf8s_pkg::Euro2;
          act_cnt      = 3'd3;
        end else if (c == utf8s_pkg::ChNelIn) begin
          act_bytes[0] = utf8s_pkg::ChLf;
          act_bytes[1] = utf8s_pkg::ChCr;
          act_cnt      = 3'd2;
        end
      end else if (c < utf8s_pkg::Lat1Hi) begin
        act_bytes[0] = utf8s_pkg::LeadC2;
        act_bytes[1] = c;
        act_cnt      = 3'd2;
      end else begin
        act_bytes[0] = utf8s_pkg::LeadC3;
        act_bytes[1] = c - utf8s_pkg::Lat1Bias;
        act_cnt      = 3'd2;
      end
    end else begin
      // Multi-byte lead: check continuation bytes in order
      need = (c < utf8s_pkg::Lead3Min) ? 2'd1 : (c < utf8s_pkg::Lead4Min) ? 2'd2 : 2'd3;
      for (int j = 1; j < utf8s_pkg::WinDepth; j++) begin
        if (2'(j) <= need && !seq_hit) begin
          if (3'(j) >= fill) begin
            seq_wait = 1'b1;
            seq_hit  = 1'b1;
          end else if (pend[j][7:6] != 2'b10) begin
            seq_bad = 1'b1;
            seq_hit = 1'b1;
          end
        end
      end
      if (seq_bad || (seq_wait && is_last)) begin
        act_bytes[0] = utf8s_pkg::Repl0;
        act_bytes[1] = utf8s_pkg::Repl1;
        act_bytes[2] = utf8s_pkg::Repl2;
        act_cnt      = 3'd3;
      end else if (seq_wait) begin
        act_stop = 1'b1;
      end else begin
        act_adv = {1'b0, need} + 3'd1;
        // Encoded C1 controls are dropped
        if (!(c == utf8s_pkg::LeadC2 && pend[1] < utf8s_pkg::Lat1Lo)) act_cnt = act_adv;
      end
    end
  end

  // Status to the controller
  assign out_free = !res_valid || !res_stall;
  always_comb begin
    stat.scan_done  = (fill == 3'd0);
    stat.act_stop   = act_stop;
    stat.act_none   = (act_cnt == 3'd0);
    stat.emit_end   = (emit_idx == 2'(emit_cnt - 3'd1));
    stat.push_ok    = !hold_valid || out_free;
    stat.fin_needed = hold_valid || is_last;
    stat.out_free   = out_free;
  end

  // Window: load new byte, or consume decoded bytes by shifting down
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 3'd0;
      is_last <= 1'b0;
    end else if (cmd.load_in) begin
      pend[fill[1:0]] <= in_byte;
      fill            <= fill + 3'd1;
      is_last         <= in_last;
    end else if (cmd.scan_step) begin
      for (int k = 0; k < utf8s_pkg::WinDepth; k++) begin
        if (3'(k) + act_adv < 3'(utf8s_pkg::WinDepth)) pend[k] <= pend[2'(3'(k) + act_adv)];
      end
      fill <= fill - act_adv;
    end
  end

  // Emit buffer
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      emit_bytes <= act_bytes;
      emit_cnt   <= act_cnt;
      emit_idx   <= 2'd0;
    end else if (cmd.emit_push) begin
      emit_idx <= emit_idx + 2'd1;
    end
  end

  // Hold slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.emit_push) begin
      hold       <= emit_bytes[emit_idx];
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  // Output register loads
  always_comb begin
    out_load       = cmd.flush || (cmd.emit_push && hold_valid);
    out_byte_next  = hold_valid ? hold : 8'd0;
    out_valid_next = hold_valid;
    out_last_next  = cmd.flush && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte  <= out_byte_next;
      out_valid <= out_valid_next;
      out_last  <= out_last_next;
    end
  end

endmodule
